// ===== rtl/tclp_pkg.sv =====
// Shared types and character constants for the text command line parser.
package tclp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_I     = 8'h49;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_P     = 8'h50;

    // Result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_SPEED = 1'b1;

    // Reply length and index of its final byte
    localparam int unsigned REPLY_LEN = 5;
    localparam logic [2:0]  REPLY_LAST = 3'd4;

    // Matcher phase, one-hot
    typedef enum logic [14:0] {
        PH_START  = 15'b000000000000001,
        PH_P      = 15'b000000000000010,
        PH_PI     = 15'b000000000000100,
        PH_PIN    = 15'b000000000001000,
        PH_PING   = 15'b000000000010000,
        PH_PINGOK = 15'b000000000100000,
        PH_M      = 15'b000000001000000,
        PH_LWS    = 15'b000000010000000,
        PH_LSIGN  = 15'b000000100000000,
        PH_LDIG   = 15'b000001000000000,
        PH_RWS    = 15'b000010000000000,
        PH_RSIGN  = 15'b000100000000000,
        PH_RDIG   = 15'b001000000000000,
        PH_MOK    = 15'b010000000000000,
        PH_FAIL   = 15'b100000000000000
    } phase_t;

    // Bytes of the PONG LF reply
    function automatic logic [7:0] reply_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CHAR_P;
            3'd1:    c = CHAR_O;
            3'd2:    c = CHAR_N;
            3'd3:    c = CHAR_G;
            3'd4:    c = CHAR_LF;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // acc * 10 + digit, modulo 2^16
    function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] c);
        logic [7:0] d;
        d = c - CHAR_ZERO;
        return (acc << 3) + (acc << 1) + {12'd0, d[3:0]};
    endfunction

endpackage

// ===== rtl/text_command_line_parser.sv =====
// Top level of the text command line parser: line matcher and result register.
//
// Takes one received byte per cycle and matches lines ending at LF or CR as they
// arrive; only the first LINE_BYTES-1 bytes of a line count. A line "PING" gives
// five reply results (P, O, N, G, LF); a line "M,<int>,<int>" of at least five
// bytes updates the held speeds and gives one speed result. Every byte is handled
// as it is taken, with no line buffer. Results leave through a single output
// register: a line terminator is taken only when that register is empty or
// handing over its final result in the same cycle, so a PING reply holds line
// terminators off until its fifth result is taken; other bytes are always taken.
module text_command_line_parser #(
    parameter int unsigned LINE_BYTES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [7:0]         m_reply_byte,
    output logic signed [15:0] m_speed_left,
    output logic signed [15:0] m_speed_right,
    output logic               m_last
);
    import tclp_pkg::*;

    localparam int unsigned CNT_W = $clog2(LINE_BYTES);
    localparam logic [CNT_W-1:0] LINE_MAX = CNT_W'(LINE_BYTES - 1);
    localparam logic [CNT_W-1:0] MIN_SPEED_LEN = CNT_W'(5);

    // Line state
    logic [CNT_W-1:0] line_count_reg, line_count_next;
    phase_t           phase_reg, phase_next;
    logic             nul_seen_reg, nul_seen_next;
    logic [15:0]      left_accum_reg, left_accum_next;
    logic [15:0]      right_accum_reg, right_accum_next;
    logic             left_neg_reg, left_neg_next;
    logic             right_neg_reg, right_neg_next;
    logic [15:0]      held_left_reg, held_left_next;
    logic [15:0]      held_right_reg, held_right_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [2:0]       beat_reg, beat_next;

    logic c_term, accept, out_last, out_free;
    logic do_pong, do_speed;

    assign c_term   = (s_rx_byte == CHAR_LF) || (s_rx_byte == CHAR_CR);
    assign out_last = (out_kind_reg == KIND_SPEED) || (beat_reg == REPLY_LAST);
    assign out_free = !out_valid_reg || (m_ready && out_last);
    assign s_ready  = out_free || !c_term;
    assign accept   = s_valid && s_ready;

    // Line end decisions
    assign do_pong  = (line_count_reg != '0) &&
                      ((phase_reg == PH_PING) || (phase_reg == PH_PINGOK));
    assign do_speed = (line_count_reg >= MIN_SPEED_LEN) &&
                      ((phase_reg == PH_RDIG) || (phase_reg == PH_MOK));

    // Matcher and line state update
    always_comb begin
        line_count_next  = line_count_reg;
        phase_next       = phase_reg;
        nul_seen_next    = nul_seen_reg;
        left_accum_next  = left_accum_reg;
        right_accum_next = right_accum_reg;
        left_neg_next    = left_neg_reg;
        right_neg_next   = right_neg_reg;
        held_left_next   = held_left_reg;
        held_right_next  = held_right_reg;
        if (accept) begin
            if (c_term) begin
                if (do_speed && !do_pong) begin
                    held_left_next  = left_neg_reg ? 16'd0 - left_accum_reg : left_accum_reg;
                    held_right_next = right_neg_reg ? 16'd0 - right_accum_reg
                                                    : right_accum_reg;
                end
                line_count_next  = '0;
                phase_next       = PH_START;
                nul_seen_next    = 1'b0;
                left_accum_next  = '0;
                right_accum_next = '0;
                left_neg_next    = 1'b0;
                right_neg_next   = 1'b0;
            end else if (line_count_reg < LINE_MAX) begin
                line_count_next = line_count_reg + 1'b1;
                if (!nul_seen_reg) begin
                    nul_seen_next = (s_rx_byte == CHAR_NUL);
                    phase_next    = PH_FAIL;
                    unique case (phase_reg)
                        PH_START: begin
                            if (s_rx_byte == CHAR_P) begin
                                phase_next = PH_P;
                            end else if (s_rx_byte == CHAR_M) begin
                                phase_next = PH_M;
                            end
                        end
                        PH_P:    if (s_rx_byte == CHAR_I) phase_next = PH_PI;
                        PH_PI:   if (s_rx_byte == CHAR_N) phase_next = PH_PIN;
                        PH_PIN:  if (s_rx_byte == CHAR_G) phase_next = PH_PING;
                        PH_PING: if (s_rx_byte == CHAR_NUL) phase_next = PH_PINGOK;
                        PH_M:    if (s_rx_byte == CHAR_COMMA) phase_next = PH_LWS;
                        PH_LWS: begin
                            if (is_blank(s_rx_byte)) begin
                                phase_next = PH_LWS;
                            end else if ((s_rx_byte == CHAR_PLUS) ||
                                         (s_rx_byte == CHAR_MINUS)) begin
                                left_neg_next = (s_rx_byte == CHAR_MINUS);
                                phase_next    = PH_LSIGN;
                            end else if (is_digit(s_rx_byte)) begin
                                left_accum_next = add_digit(left_accum_reg, s_rx_byte);
                                phase_next      = PH_LDIG;
                            end
                        end
                        PH_LSIGN, PH_LDIG: begin
                            if (is_digit(s_rx_byte)) begin
                                left_accum_next = add_digit(left_accum_reg, s_rx_byte);
                                phase_next      = PH_LDIG;
                            end else if ((phase_reg == PH_LDIG) &&
                                         (s_rx_byte == CHAR_COMMA)) begin
                                phase_next = PH_RWS;
                            end
                        end
                        PH_RWS: begin
                            if (is_blank(s_rx_byte)) begin
                                phase_next = PH_RWS;
                            end else if ((s_rx_byte == CHAR_PLUS) ||
                                         (s_rx_byte == CHAR_MINUS)) begin
                                right_neg_next = (s_rx_byte == CHAR_MINUS);
                                phase_next     = PH_RSIGN;
                            end else if (is_digit(s_rx_byte)) begin
                                right_accum_next = add_digit(right_accum_reg, s_rx_byte);
                                phase_next       = PH_RDIG;
                            end
                        end
                        PH_RSIGN: begin
                            if (is_digit(s_rx_byte)) begin
                                right_accum_next = add_digit(right_accum_reg, s_rx_byte);
                                phase_next       = PH_RDIG;
                            end
                        end
                        PH_RDIG: begin
                            if (is_digit(s_rx_byte)) begin
                                right_accum_next = add_digit(right_accum_reg, s_rx_byte);
                                phase_next       = PH_RDIG;
                            end else begin
                                phase_next = PH_MOK;
                            end
                        end
                        PH_PINGOK: phase_next = PH_PINGOK;
                        PH_MOK:    phase_next = PH_MOK;
                        PH_FAIL:   phase_next = PH_FAIL;
                        default:   phase_next = PH_FAIL;
                    endcase
                end
            end
        end
    end

    // Output register: load on a matched line end, else step through the reply and empty after the last result
    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        beat_next      = beat_reg;
        if (out_valid_reg && m_ready) begin
            if (out_last) begin
                out_valid_next = 1'b0;
            end else begin
                beat_next = beat_reg + 3'd1;
            end
        end
        if (accept && c_term && (do_pong || do_speed)) begin
            out_valid_next = 1'b1;
            out_kind_next  = do_pong ? KIND_REPLY : KIND_SPEED;
            beat_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg  <= '0;
            phase_reg       <= PH_START;
            nul_seen_reg    <= 1'b0;
            left_accum_reg  <= '0;
            right_accum_reg <= '0;
            left_neg_reg    <= 1'b0;
            right_neg_reg   <= 1'b0;
            held_left_reg   <= '0;
            held_right_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= KIND_REPLY;
            beat_reg        <= '0;
        end else begin
            line_count_reg  <= line_count_next;
            phase_reg       <= phase_next;
            nul_seen_reg    <= nul_seen_next;
            left_accum_reg  <= left_accum_next;
            right_accum_reg <= right_accum_next;
            left_neg_reg    <= left_neg_next;
            right_neg_reg   <= right_neg_next;
            held_left_reg   <= held_left_next;
            held_right_reg  <= held_right_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            beat_reg        <= beat_next;
        end
    end

    // Result ports; speeds only change with a speed result of their own
    assign m_valid       = out_valid_reg;
    assign m_kind        = out_kind_reg;
    assign m_reply_byte  = (out_kind_reg == KIND_SPEED) ? CHAR_NUL : reply_char(beat_reg);
    assign m_speed_left  = held_left_reg;
    assign m_speed_right = held_right_reg;
    assign m_last        = out_last;

`ifndef SYNTHESIS
    // A line terminator is only taken when the result register can take a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && c_term) |-> (!m_valid || (m_ready && m_last)))
        else $error("terminator accepted while result register busy");

    // The reply always closes with LF
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_REPLY) && m_last) |-> (m_reply_byte == CHAR_LF))
        else $error("reply does not end in LF");

    // A speed result stands alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_SPEED)) |-> (m_last && (m_reply_byte == CHAR_NUL)))
        else $error("speed result malformed");

    // Kept length never passes the line limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        line_count_reg <= LINE_MAX)
        else $error("line count past limit");

    // Held speeds move only with a speed result being loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && (m_kind == KIND_SPEED)) |-> $stable(held_left_reg) ||
        ($past(accept) && $past(c_term)))
        else $error("held speed changed without a speed result");
`endif

endmodule

// ===== tb/tclp_result_checker.sv =====
// Checker for the text command line parser: predicts results per request and compares them.
`timescale 1ns / 1ps

module tclp_result_checker #(
    parameter int unsigned LINE_BYTES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_kind,
    input  logic [7:0]         m_reply_byte,
    input  logic signed [15:0] m_speed_left,
    input  logic signed [15:0] m_speed_right,
    input  logic               m_last,
    output int unsigned        mismatches,
    output int unsigned        outstanding
);
    import tclp_pkg::*;

    // Reply text, first byte in the top bits
    localparam logic [39:0] PONG_TEXT = {CHAR_P, CHAR_O, CHAR_N, CHAR_G, CHAR_LF};

    typedef struct packed {
        logic               kind;
        logic [7:0]         reply_byte;
        logic signed [15:0] speed_left;
        logic signed [15:0] speed_right;
        logic               last;
    } parser_result_t;

    parser_result_t pending_results[$];
    int unsigned    fail_count;

    // Predicted line state
    logic [8:0]  line_len;
    phase_t      phase;
    logic        nul_hit;
    logic [15:0] left_mag;
    logic [15:0] right_mag;
    logic        left_neg;
    logic        right_neg;
    logic [15:0] held_left;
    logic [15:0] held_right;

    assign mismatches = fail_count;

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

    function automatic logic decimal_char(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic [15:0] shift_in_digit(input logic [15:0] acc,
                                                  input logic [7:0] c);
        logic [7:0] d;
        d = c - CHAR_ZERO;
        return acc * 16'd10 + {8'd0, d};
    endfunction

    task automatic clear_line_state();
        line_len  = '0;
        phase     = PH_START;
        nul_hit   = 1'b0;
        left_mag  = '0;
        right_mag = '0;
        left_neg  = 1'b0;
        right_neg = 1'b0;
    endtask

    // One kept byte through the line matcher
    task automatic match_char(input logic [7:0] c);
        phase_t nxt;
        nxt = PH_FAIL;
        case (phase)
            PH_START: begin
                if (c == CHAR_P)      nxt = PH_P;
                else if (c == CHAR_M) nxt = PH_M;
            end
            PH_P:    if (c == CHAR_I) nxt = PH_PI;
            PH_PI:   if (c == CHAR_N) nxt = PH_PIN;
            PH_PIN:  if (c == CHAR_G) nxt = PH_PING;
            PH_PING: if (c == CHAR_NUL) nxt = PH_PINGOK;
            PH_M:    if (c == CHAR_COMMA) nxt = PH_LWS;
            PH_LWS: begin
                if (blank_char(c)) begin
                    nxt = PH_LWS;
                end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                    left_neg = (c == CHAR_MINUS);
                    nxt = PH_LSIGN;
                end else if (decimal_char(c)) begin
                    left_mag = shift_in_digit(left_mag, c);
                    nxt = PH_LDIG;
                end
            end
            PH_LSIGN, PH_LDIG: begin
                if (decimal_char(c)) begin
                    left_mag = shift_in_digit(left_mag, c);
                    nxt = PH_LDIG;
                end else if (phase == PH_LDIG && c == CHAR_COMMA) begin
                    nxt = PH_RWS;
                end
            end
            PH_RWS: begin
                if (blank_char(c)) begin
                    nxt = PH_RWS;
                end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                    right_neg = (c == CHAR_MINUS);
                    nxt = PH_RSIGN;
                end else if (decimal_char(c)) begin
                    right_mag = shift_in_digit(right_mag, c);
                    nxt = PH_RDIG;
                end
            end
            PH_RSIGN: begin
                if (decimal_char(c)) begin
                    right_mag = shift_in_digit(right_mag, c);
                    nxt = PH_RDIG;
                end
            end
            PH_RDIG: begin
                if (decimal_char(c)) begin
                    right_mag = shift_in_digit(right_mag, c);
                    nxt = PH_RDIG;
                end else begin
                    nxt = PH_MOK;
                end
            end
            PH_PINGOK: nxt = PH_PINGOK;
            PH_MOK:    nxt = PH_MOK;
            default:   nxt = PH_FAIL;
        endcase
        phase = nxt;
    endtask

    // Work out the results caused by one accepted request
    task automatic predict_results(input logic [7:0] c);
        parser_result_t r;
        int i;
        if (c == CHAR_LF || c == CHAR_CR) begin
            if (line_len != 0) begin
                if (phase == PH_PING || phase == PH_PINGOK) begin
                    for (i = 0; i < REPLY_LEN; i++) begin
                        r.kind        = KIND_REPLY;
                        r.reply_byte  = PONG_TEXT[39 - 8 * i -: 8];
                        r.speed_left  = held_left;
                        r.speed_right = held_right;
                        r.last        = (i == REPLY_LEN - 1);
                        pending_results.push_back(r);
                    end
                end else if (line_len >= 5 && (phase == PH_RDIG || phase == PH_MOK)) begin
                    held_left     = left_neg ? 16'd0 - left_mag : left_mag;
                    held_right    = right_neg ? 16'd0 - right_mag : right_mag;
                    r.kind        = KIND_SPEED;
                    r.reply_byte  = CHAR_NUL;
                    r.speed_left  = held_left;
                    r.speed_right = held_right;
                    r.last        = 1'b1;
                    pending_results.push_back(r);
                end
            end
            clear_line_state();
        end else if (line_len < LINE_BYTES - 1) begin
            line_len = line_len + 9'd1;
            if (!nul_hit) begin
                match_char(c);
                if (c == CHAR_NUL) nul_hit = 1'b1;
            end
        end
    endtask

    // Requests first, then results; the queue keeps the order either way
    always @(posedge aclk) begin
        parser_result_t want;
        if (!aresetn) begin
            clear_line_state();
            held_left  = '0;
            held_right = '0;
            pending_results.delete();
            fail_count = 0;
        end else begin
            if (s_valid && s_ready) predict_results(s_rx_byte);
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d reply_byte %h left %0d right %0d",
                           m_kind, m_reply_byte, m_speed_left, m_speed_right);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_kind);
                        fail_count++;
                    end
                    if (m_reply_byte !== want.reply_byte) begin
                        $error("reply_byte: expected %h, actual %h",
                               want.reply_byte, m_reply_byte);
                        fail_count++;
                    end
                    if (m_speed_left !== want.speed_left) begin
                        $error("speed_left: expected %0d, actual %0d",
                               want.speed_left, m_speed_left);
                        fail_count++;
                    end
                    if (m_speed_right !== want.speed_right) begin
                        $error("speed_right: expected %0d, actual %0d",
                               want.speed_right, m_speed_right);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_last);
                        fail_count++;
                    end
                end
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

// ===== tb/tb_text_command_line_parser.sv =====
// Top of the text command line parser testbench: clock, reset, line stimulus and verdict.
`timescale 1ns / 1ps

module tb_text_command_line_parser;
    import tclp_pkg::*;

    localparam int unsigned LINE_BYTES   = 64;
    localparam int unsigned TOTAL_BYTES  = 420;
    localparam int unsigned CALM_BYTES   = 60;
    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES = 40;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'd0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic               m_kind;
    logic [7:0]         m_reply_byte;
    logic signed [15:0] m_speed_left;
    logic signed [15:0] m_speed_right;
    logic               m_last;

    int unsigned mismatches;
    int unsigned outstanding;

    // Stimulus controls
    bit          idle_on = 1'b1;
    bit          mangle  = 1'b0;
    int unsigned sent_count = 0;
    int unsigned ready_stall = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    text_command_line_parser #(.LINE_BYTES(LINE_BYTES)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_reply_byte  (m_reply_byte),
        .m_speed_left  (m_speed_left),
        .m_speed_right (m_speed_right),
        .m_last        (m_last)
    );

    tclp_result_checker #(.LINE_BYTES(LINE_BYTES)) result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_reply_byte  (m_reply_byte),
        .m_speed_left  (m_speed_left),
        .m_speed_right (m_speed_right),
        .m_last        (m_last),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Result side back-pressure in random bursts, only while idle_on is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            ready_stall <= 0;
        end else if (ready_stall != 0) begin
            m_ready     <= 1'b0;
            ready_stall <= ready_stall - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready     <= 1'b0;
            ready_stall <= $urandom_range(0, 16);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: cycles with no handshake on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // One request; optional gap before it, optional corruption of the byte
    task automatic send_byte(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (mangle && $urandom_range(0, 11) == 0) v = 8'($urandom_range(0, 255));
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Blanks, optional sign, decimal digits
    task automatic send_operand();
        int unsigned mag;
        int unsigned n;
        n = $urandom_range(0, 2);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: send_byte(CHAR_SPACE);
                1: send_byte(CHAR_TAB);
                2: send_byte(CHAR_VT);
                default: send_byte(CHAR_FF);
            endcase
        end
        case ($urandom_range(0, 2))
            1: send_byte(CHAR_PLUS);
            2: send_byte(CHAR_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: mag = $urandom_range(0, 9);
            1: mag = $urandom_range(0, 32768);
            2: mag = $urandom_range(0, 65535);
            default: mag = $urandom_range(0, 9999999);
        endcase
        if ($urandom_range(0, 7) == 0) send_byte(CHAR_ZERO);
        send_text($sformatf("%0d", mag));
    endtask

    initial begin
        logic [7:0]  b;
        int unsigned n;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines
        send_byte(CHAR_LF);
        send_text("PING");
        send_byte(CHAR_LF);
        send_text("PING");
        send_byte(CHAR_NUL);
        send_text("x");
        send_byte(CHAR_CR);
        send_text("M,-32768,+32767");
        send_byte(CHAR_LF);
        send_text("M,99999,65535");
        send_byte(CHAR_CR);
        send_text("M,");
        send_byte(CHAR_TAB);
        send_byte(CHAR_VT);
        send_byte(CHAR_FF);
        send_byte(CHAR_SPACE);
        send_text("-0,");
        send_byte(CHAR_SPACE);
        send_text("7 rest");
        send_byte(CHAR_LF);
        send_text("M,1,2");
        send_byte(CHAR_LF);
        send_text("M,1 ,2");
        send_byte(CHAR_LF);
        send_text("M,1,2");
        send_byte(CHAR_NUL);
        send_byte(8'hFF);
        send_byte(CHAR_LF);
        send_text("PINGS");
        send_byte(CHAR_CR);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(CHAR_LF);
        send_text("M,5");
        send_byte(CHAR_LF);
        send_text("M,+,1");
        send_byte(CHAR_LF);
        // Over-long lines: a complete match still counts, a late PING does not
        send_text("M,-3,4");
        repeat (70) send_text("Z");
        send_byte(CHAR_LF);
        repeat (60) send_text("A");
        send_text("PING");
        send_byte(CHAR_LF);
        send_text("PING");
        send_byte(CHAR_NUL);
        repeat (70) send_byte(8'hFF);
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);

        // Random lines, mostly well formed, up to the request total
        while (sent_count < TOTAL_BYTES) begin
            idle_on = (sent_count + CALM_BYTES < TOTAL_BYTES) && ($urandom_range(0, 3) != 0);
            mangle  = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    send_text("PING");
                    if ($urandom_range(0, 2) == 0) begin
                        send_byte(CHAR_NUL);
                        send_byte(8'($urandom_range(0, 255)));
                    end
                end
                4, 5, 6, 7, 8, 9, 10, 11, 12: begin
                    send_text("M,");
                    send_operand();
                    send_byte(CHAR_COMMA);
                    send_operand();
                    case ($urandom_range(0, 3))
                        1: send_text(" trailing");
                        2: begin
                            send_byte(CHAR_NUL);
                            send_byte(8'($urandom_range(0, 255)));
                        end
                        3: send_byte(8'($urandom_range(0, 255)));
                        default: ;
                    endcase
                end
                13, 14, 15: begin
                    n = $urandom_range(1, 12);
                    repeat (n) send_byte(8'($urandom_range(0, 255)));
                end
                16, 17: ;
                default: begin
                    case ($urandom_range(0, 2))
                        0: send_text("M,12,-34");
                        1: send_text("PING");
                        default: ;
                    endcase
                    n = $urandom_range(55, 75);
                    repeat (n) begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == CHAR_LF || b == CHAR_CR);
                        send_byte(b);
                    end
                end
            endcase
            send_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
        end

        // Drain
        mangle  = 1'b0;
        idle_on = 1'b0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
